@@ design/vcms_pkg.sv @@
// Shared types, codes and constants of the velocity command mux and smoother.
package vcms_pkg;

   localparam int VEL_W      = 16;
   localparam int CMD_W      = 3;
   localparam int HEALTH_W   = 3;
   localparam int MODE_W     = 2;
   localparam int TICK_W     = 16;
   localparam int ALPHA_W    = 17;
   localparam int ALPHA_FRAC = 16;
   localparam int LIM_W      = 15;
   localparam int THR_W      = 15;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam int SQ_CMP_W  = (2 * VEL_W + 1 > 2 * THR_W) ? 2 * VEL_W + 1 : 2 * THR_W;
   localparam int MAG_CMP_W = (VEL_W > THR_W) ? VEL_W : THR_W;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

   localparam logic [CMD_W-1:0] CMD_MANUAL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_AUTO   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HEALTH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SAFETY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

   localparam logic [HEALTH_W-1:0] HEALTH_DEGRADED   = 3'd1;
   localparam logic [HEALTH_W-1:0] HEALTH_EMERGENCY  = 3'd2;
   localparam logic [HEALTH_W-1:0] HEALTH_PROTECTIVE = 3'd3;
   localparam logic [HEALTH_W-1:0] HEALTH_RECONFIG   = 3'd4;

   localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MANUAL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BLOCKED = 2'd3;

   localparam logic KIND_VELOCITY = 1'b0;
   localparam logic KIND_CANCEL   = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HOLD     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ALPHA    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LIM_NORM = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LIM_DEGR = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STILL    = 3'd5;

   localparam logic [TICK_W-1:0]  RST_TIMEOUT  = 16'd50;
   localparam logic [TICK_W-1:0]  RST_HOLD     = 16'd200;
   localparam logic [ALPHA_W-1:0] RST_ALPHA    = 17'd6554;
   localparam logic [LIM_W-1:0]   RST_LIM_NORM = 15'd4096;
   localparam logic [LIM_W-1:0]   RST_LIM_DEGR = 15'd1229;
   localparam logic [THR_W-1:0]   RST_STILL    = 15'd4;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [VEL_W-1:0] lin_x;
      logic signed [VEL_W-1:0] lin_y;
      logic signed [VEL_W-1:0] ang_z;
      logic [HEALTH_W-1:0]     health_code;
      logic                    estop_active;
   } req_type;

   typedef struct packed {
      logic                    result_kind;
      logic signed [VEL_W-1:0] out_lin_x;
      logic signed [VEL_W-1:0] out_lin_y;
      logic signed [VEL_W-1:0] out_ang_z;
      logic [MODE_W-1:0]       mux_mode;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]  command_timeout_ticks;
      logic [TICK_W-1:0]  takeover_hold_ticks;
      logic [ALPHA_W-1:0] smoothing_alpha;
      logic [LIM_W-1:0]   speed_limit_normal;
      logic [LIM_W-1:0]   speed_limit_degraded;
      logic [THR_W-1:0]   still_threshold;
   } cfg_type;

endpackage

@@ design/velocity_command_mux_smoother_top.sv @@
// Top level of the velocity command mux and smoother: channel registers and wiring.
//
// The block takes one item per clock cycle. Each transfer is captured in an input
// register; from there the mode machine, the still check and the three per-axis
// smoothing multipliers update the state, and any result lands in an output
// register. The state update (one multiply, round and clamp per axis feeding the
// smoothed velocity back) is combinational from the input register to the state
// registers and sets the rate. Input transfers are stalled only while the output
// register holds a result that is stalled. There is no clearing pass after reset;
// configuration is read back at the written addresses.
module velocity_command_mux_smoother_top #(
   parameter int AGE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  vcms_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output vcms_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vcms_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [vcms_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [vcms_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import vcms_pkg::*;

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff, item_valid_in;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    core_valid;
   rsp_type core_res;

   vcms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vcms_core #(
      .AGE_WIDTH (AGE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .commit    (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .res_valid (core_valid),
      .res       (core_res)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      item_valid_in = req_stall ? item_valid_ff : req_valid;
      if (advance && core_valid) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
      if (advance && core_valid) begin
         rsp_data_ff <= core_res;
      end
   end

   a_cancel_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.result_kind == KIND_CANCEL
      |-> rsp_data_ff.mux_mode == MODE_MANUAL && rsp_data_ff.out_lin_x == '0
          && rsp_data_ff.out_lin_y == '0 && rsp_data_ff.out_ang_z == '0)
      else $error("cancel result carries a velocity or a wrong mode");

   a_result_captured: assert property (@(posedge clock) disable iff (reset)
      advance && core_valid |=> rsp_valid_ff && rsp_data_ff == $past(core_res))
      else $error("result of a committed item was not captured");

endmodule

@@ design/vcms_csr.sv @@
// Configuration register file with an APB-style access port.
module vcms_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vcms_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [vcms_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [vcms_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output vcms_pkg::cfg_type                cfg
);
   import vcms_pkg::*;

   cfg_type              cfg_ff;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_timeout_ticks <= RST_TIMEOUT;
         cfg_ff.takeover_hold_ticks   <= RST_HOLD;
         cfg_ff.smoothing_alpha       <= RST_ALPHA;
         cfg_ff.speed_limit_normal    <= RST_LIM_NORM;
         cfg_ff.speed_limit_degraded  <= RST_LIM_DEGR;
         cfg_ff.still_threshold       <= RST_STILL;
      end else if (wr_en) begin
         case (reg_idx)
            REG_TIMEOUT:  cfg_ff.command_timeout_ticks <= csr_pwdata[TICK_W-1:0];
            REG_HOLD:     cfg_ff.takeover_hold_ticks   <= csr_pwdata[TICK_W-1:0];
            REG_ALPHA:    cfg_ff.smoothing_alpha       <= csr_pwdata[ALPHA_W-1:0];
            REG_LIM_NORM: cfg_ff.speed_limit_normal    <= csr_pwdata[LIM_W-1:0];
            REG_LIM_DEGR: cfg_ff.speed_limit_degraded  <= csr_pwdata[LIM_W-1:0];
            REG_STILL:    cfg_ff.still_threshold       <= csr_pwdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TIMEOUT:  csr_prdata = CSR_DATA_W'(cfg_ff.command_timeout_ticks);
         REG_HOLD:     csr_prdata = CSR_DATA_W'(cfg_ff.takeover_hold_ticks);
         REG_ALPHA:    csr_prdata = CSR_DATA_W'(cfg_ff.smoothing_alpha);
         REG_LIM_NORM: csr_prdata = CSR_DATA_W'(cfg_ff.speed_limit_normal);
         REG_LIM_DEGR: csr_prdata = CSR_DATA_W'(cfg_ff.speed_limit_degraded);
         REG_STILL:    csr_prdata = CSR_DATA_W'(cfg_ff.still_threshold);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

@@ design/vcms_ema_axis.sv @@
// One axis of the exponential smoother with rounding and symmetric clamp.
module vcms_ema_axis (
   input  logic signed [vcms_pkg::VEL_W-1:0] target,
   input  logic signed [vcms_pkg::VEL_W-1:0] prev,
   input  logic [vcms_pkg::ALPHA_W-1:0]      alpha,
   input  logic [vcms_pkg::LIM_W-1:0]        limit,
   output logic signed [vcms_pkg::VEL_W-1:0] result
);
   import vcms_pkg::*;

   localparam int PW = VEL_W + 1 + ALPHA_W + 1;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] HALF = SW'(1 << (ALPHA_FRAC - 1));

   logic [ALPHA_W-1:0]       alpha_eff;
   logic signed [ALPHA_W:0]  alpha_s;
   logic signed [VEL_W:0]    diff;
   logic signed [PW-1:0]     prod;
   logic signed [SW-1:0]     prev_sh;
   logic signed [SW-1:0]     sum;
   logic signed [SW-1:0]     rnd;
   logic signed [SW-1:0]     lim_pos;
   logic signed [SW-1:0]     lim_neg;
   logic signed [SW-1:0]     clamped;

   // new = prev + alpha * (target - prev), alpha in unsigned Q1.16, with round half up.
   always_comb begin
      alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
      alpha_s   = $signed({1'b0, alpha_eff});
      diff      = $signed({target[VEL_W-1], target}) - $signed({prev[VEL_W-1], prev});
      prod      = PW'(alpha_s) * PW'(diff);
      prev_sh   = SW'(prev) <<< ALPHA_FRAC;
      sum       = prev_sh + SW'(prod) + HALF;
      rnd       = sum >>> ALPHA_FRAC;
      lim_pos   = $signed(SW'(limit));
      lim_neg   = -lim_pos;
      if (rnd > lim_pos) begin
         clamped = lim_pos;
      end else if (rnd < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = rnd;
      end
      result = clamped[VEL_W-1:0];
   end

endmodule

@@ design/vcms_core.sv @@
// Mode machine, source ages, stored commands and smoothed velocity state.
module vcms_core #(
   parameter int AGE_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  vcms_pkg::req_type item,
   input  vcms_pkg::cfg_type cfg,
   output logic              res_valid,
   output vcms_pkg::rsp_type res
);
   import vcms_pkg::*;

   localparam int AGE_CMP_W = (AGE_WIDTH > TICK_W) ? AGE_WIDTH : TICK_W;
   localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [AGE_WIDTH-1:0]    manual_age_ff, manual_age_in;
   logic [AGE_WIDTH-1:0]    auto_age_ff, auto_age_in;
   logic signed [VEL_W-1:0] manual_cmd_ff [3];
   logic signed [VEL_W-1:0] manual_cmd_in [3];
   logic signed [VEL_W-1:0] auto_cmd_ff [3];
   logic signed [VEL_W-1:0] auto_cmd_in [3];
   logic signed [VEL_W-1:0] smooth_ff [3];
   logic signed [VEL_W-1:0] smooth_in [3];
   logic                    degraded_ff, degraded_in;
   logic                    health_blk_ff, health_blk_in;
   logic                    estop_blk_ff, estop_blk_in;

   logic signed [VEL_W-1:0] vel [3];
   logic signed [VEL_W-1:0] target [3];
   logic signed [VEL_W-1:0] ema_out [3];
   logic                    blocked;
   logic [VEL_W-1:0]        mag_x, mag_y, mag_z;
   logic [2*VEL_W-1:0]      sq_x, sq_y;
   logic [2*VEL_W:0]        planar;
   logic [2*THR_W-1:0]      thr_sq;
   logic                    still;
   logic [AGE_WIDTH-1:0]    man_tick, auto_tick;
   logic                    timed_out;
   logic                    hold_active;
   logic                    use_cmd;
   logic [LIM_W-1:0]        limit;

   assign vel[0]  = item.lin_x;
   assign vel[1]  = item.lin_y;
   assign vel[2]  = item.ang_z;
   assign blocked = health_blk_ff || estop_blk_ff;

   always_comb begin
      mag_x  = item.lin_x[VEL_W-1] ? VEL_W'(-item.lin_x) : VEL_W'(item.lin_x);
      mag_y  = item.lin_y[VEL_W-1] ? VEL_W'(-item.lin_y) : VEL_W'(item.lin_y);
      mag_z  = item.ang_z[VEL_W-1] ? VEL_W'(-item.ang_z) : VEL_W'(item.ang_z);
      sq_x   = (2*VEL_W)'(mag_x) * (2*VEL_W)'(mag_x);
      sq_y   = (2*VEL_W)'(mag_y) * (2*VEL_W)'(mag_y);
      planar = {1'b0, sq_x} + {1'b0, sq_y};
      thr_sq = (2*THR_W)'(cfg.still_threshold) * (2*THR_W)'(cfg.still_threshold);
      still  = (SQ_CMP_W'(planar) < SQ_CMP_W'(thr_sq))
            && (MAG_CMP_W'(mag_z) < MAG_CMP_W'(cfg.still_threshold));
   end

   always_comb begin
      man_tick  = (manual_age_ff == AGE_MAX) ? manual_age_ff
                                             : manual_age_ff + AGE_WIDTH'(1);
      auto_tick = (auto_age_ff == AGE_MAX) ? auto_age_ff : auto_age_ff + AGE_WIDTH'(1);
      timed_out = (AGE_CMP_W'(man_tick) > AGE_CMP_W'(cfg.command_timeout_ticks))
               && (AGE_CMP_W'(auto_tick) > AGE_CMP_W'(cfg.command_timeout_ticks));
      hold_active = AGE_CMP_W'(manual_age_ff) < AGE_CMP_W'(cfg.takeover_hold_ticks);
      use_cmd = !blocked && (mode_ff == MODE_MANUAL || mode_ff == MODE_AUTO) && !timed_out;
      limit   = degraded_ff ? cfg.speed_limit_degraded : cfg.speed_limit_normal;
      for (int i = 0; i < 3; i++) begin
         if (!use_cmd) begin
            target[i] = '0;
         end else if (mode_ff == MODE_MANUAL) begin
            target[i] = manual_cmd_ff[i];
         end else begin
            target[i] = auto_cmd_ff[i];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      vcms_ema_axis u_ema (
         .target (target[g]),
         .prev   (smooth_ff[g]),
         .alpha  (cfg.smoothing_alpha),
         .limit  (limit),
         .result (ema_out[g])
      );
   end

   always_comb begin
      mode_in       = mode_ff;
      manual_age_in = manual_age_ff;
      auto_age_in   = auto_age_ff;
      manual_cmd_in = manual_cmd_ff;
      auto_cmd_in   = auto_cmd_ff;
      smooth_in     = smooth_ff;
      degraded_in   = degraded_ff;
      health_blk_in = health_blk_ff;
      estop_blk_in  = estop_blk_ff;
      res_valid     = 1'b0;
      res           = '0;
      case (item.command)
         CMD_MANUAL: begin
            if (!blocked) begin
               manual_cmd_in = vel;
               if (!still) begin
                  manual_age_in = '0;
                  mode_in       = MODE_MANUAL;
                  if (mode_ff == MODE_AUTO) begin
                     res_valid        = commit;
                     res.result_kind  = KIND_CANCEL;
                     res.mux_mode     = MODE_MANUAL;
                  end
               end
            end
         end
         CMD_AUTO: begin
            if (!blocked) begin
               auto_age_in = '0;
               if (!hold_active) begin
                  mode_in     = MODE_AUTO;
                  auto_cmd_in = vel;
               end
            end
         end
         CMD_HEALTH: begin
            degraded_in   = item.health_code == HEALTH_DEGRADED;
            health_blk_in = item.health_code == HEALTH_EMERGENCY
                         || item.health_code == HEALTH_PROTECTIVE
                         || item.health_code == HEALTH_RECONFIG;
         end
         CMD_SAFETY: begin
            estop_blk_in = item.estop_active;
         end
         CMD_TICK: begin
            manual_age_in = man_tick;
            auto_age_in   = auto_tick;
            if (blocked) begin
               mode_in = MODE_BLOCKED;
            end else if (!use_cmd) begin
               mode_in = MODE_IDLE;
            end
            smooth_in       = ema_out;
            res_valid       = commit;
            res.result_kind = KIND_VELOCITY;
            res.out_lin_x   = ema_out[0];
            res.out_lin_y   = ema_out[1];
            res.out_ang_z   = ema_out[2];
            res.mux_mode    = mode_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         manual_age_ff <= AGE_MAX;
         auto_age_ff   <= AGE_MAX;
         degraded_ff   <= 1'b0;
         health_blk_ff <= 1'b0;
         estop_blk_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            manual_cmd_ff[i] <= '0;
            auto_cmd_ff[i]   <= '0;
            smooth_ff[i]     <= '0;
         end
      end else if (commit) begin
         mode_ff       <= mode_in;
         manual_age_ff <= manual_age_in;
         auto_age_ff   <= auto_age_in;
         degraded_ff   <= degraded_in;
         health_blk_ff <= health_blk_in;
         estop_blk_ff  <= estop_blk_in;
         manual_cmd_ff <= manual_cmd_in;
         auto_cmd_ff   <= auto_cmd_in;
         smooth_ff     <= smooth_in;
      end
   end

   a_tick_blocked: assert property (@(posedge clock) disable iff (reset)
      commit && item.command == CMD_TICK && blocked |=> mode_ff == MODE_BLOCKED)
      else $error("tick while blocked did not enter blocked mode");

   a_takeover: assert property (@(posedge clock) disable iff (reset)
      commit && item.command == CMD_MANUAL && !blocked && !still
      |=> manual_age_ff == '0 && mode_ff == MODE_MANUAL)
      else $error("manual takeover did not restart the hold");

   a_smooth_follows: assert property (@(posedge clock) disable iff (reset)
      commit && item.command == CMD_TICK
      |=> smooth_ff[0] == $past(res.out_lin_x) && smooth_ff[2] == $past(res.out_ang_z))
      else $error("smoothed state differs from the reported velocity");

endmodule
